[rtl/stiff_bar_finite_difference_synth_top_macros.svh]
// Assertion macros shared by the stiff bar synthesizer RTL.
`ifndef STIFF_BAR_FINITE_DIFFERENCE_SYNTH_TOP_MACROS_SVH
`define STIFF_BAR_FINITE_DIFFERENCE_SYNTH_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SBFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SBFD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SBFD_ASSERT(lbl, prop, msg)
`define SBFD_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/sbfd_pkg.sv]
// Types and constants of the stiff bar synthesizer.
package sbfd_pkg;

	localparam int DEF_MAX_POINTS   = 128;
	localparam int DEF_SAMPLE_WIDTH = 32;

	localparam logic [2:0] CFG_COEF_CENTER     = 3'd0;
	localparam logic [2:0] CFG_COEF_NEAR       = 3'd1;
	localparam logic [2:0] CFG_COEF_FAR        = 3'd2;
	localparam logic [2:0] CFG_COEF_OLD_CENTER = 3'd3;
	localparam logic [2:0] CFG_COEF_OLD_NEAR   = 3'd4;
	localparam logic [2:0] CFG_GRID_POINTS     = 3'd5;
	localparam logic [2:0] CFG_LEFT_END_MODE   = 3'd6;
	localparam logic [2:0] CFG_RIGHT_END_MODE  = 3'd7;

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_STRIKE = 1'b1;

	localparam logic [7:0] GRID_POINTS_RST = 8'd64;

	typedef enum logic [1:0] {
		END_NONE    = 2'd0,
		END_CLAMPED = 2'd1,
		END_PIVOT   = 2'd2,
		END_FREE    = 2'd3
	} end_mode_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ROT_MUL,
		ST_ROT_SUM,
		ST_POS,
		ST_B_RD_E,
		ST_B_RD_I,
		ST_B_CAP,
		ST_B_WR1,
		ST_B_WR2,
		ST_STREAM,
		ST_DRAIN,
		ST_RD_A,
		ST_RD_B,
		ST_CAP_B,
		ST_MUL,
		ST_FIN
	} sbfd_state_t;

endpackage

[rtl/sbfd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module sbfd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/stiff_bar_finite_difference_synth_top.sv]
// Top level of the stiff bar finite-difference synthesizer.
// A tick transaction runs the scan rotation, the boundary steps at both ends, a grid update
// that streams one point per cycle through the previous/older grid RAM read ports, and the
// readout; a strike write transaction is taken directly from idle.
// One result per tick; the next item is taken once the previous tick has its result stored.
// After reset the grid and strike RAMs are cleared; no input transaction is accepted meanwhile,
// configuration writes are taken at any time.
`include "stiff_bar_finite_difference_synth_top_macros.svh"
module stiff_bar_finite_difference_synth_top
	import sbfd_pkg::*;
#(
	parameter int MAX_POINTS   = DEF_MAX_POINTS,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_wdata,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// strike_index, strike_amount, scan_step_cos, scan_step_sin, one zero pad bit
	input  logic [103:0]  s_axis_tdata,
	// cmd
	input  logic          s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// sample_value
	output logic [31:0]   m_axis_tdata,
	// saturated
	output logic          m_axis_tuser
);

	localparam int GW    = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
	localparam int DEPTH = MAX_POINTS + 5;
	localparam int AW    = $clog2(DEPTH);
	localparam int PAW   = $clog2(MAX_POINTS);
	localparam int NW    = $clog2(MAX_POINTS + 1);
	localparam int ACC   = 68;
	localparam int PW1   = 32 + GW;
	localparam int PW2   = 33 + GW;
	localparam logic signed [ACC-1:0] GMAX = {{(ACC-GW+1){1'b0}}, {(GW-1){1'b1}}};
	localparam logic signed [ACC-1:0] GMIN = ~GMAX;
	localparam logic signed [ACC-1:0] RND28 = ACC'(1) <<< 27;
	localparam logic signed [64:0] RND30 = 65'sd536870912;
	localparam logic signed [64:0] UNIT_P = 65'sd1073741824;
	localparam logic signed [64:0] UNIT_N = -65'sd1073741824;
	localparam logic signed [GW+33:0] RND31 = (GW+34)'(1) <<< 30;

	function automatic logic [GW:0] sat_grid(input logic signed [ACC-1:0] v);
		logic [GW:0] r;
		if (v > GMAX) begin
			r = {1'b1, GMAX[GW-1:0]};
		end else if (v < GMIN) begin
			r = {1'b1, GMIN[GW-1:0]};
		end else begin
			r = {1'b0, v[GW-1:0]};
		end
		return r;
	endfunction

	// Control and configuration registers
	sbfd_state_t state_q, state_d;
	logic clear_q;
	logic [AW-1:0] clr_cnt_q;
	logic signed [31:0] coef_c_q, coef_n_q, coef_f_q, coef_oc_q, coef_on_q;
	logic [7:0] gp_q;
	end_mode_t lmode_q, rmode_q;
	logic signed [31:0] sc_q, ss_q, sine_q, cos_q;
	logic struck_q, flag_q, side_q;
	logic [1:0] nw_q, prev_idx, old_idx;
	logic [NW-1:0] n_q, n_d, idx_q;
	logic [30:0] frac_q;
	logic [AW-1:0] k_q, n_a, kr;
	logic signed [63:0] rsc_q, rcs_q, rcc_q, rss_q;
	logic signed [GW-1:0] e_q, i_q, v1_q, v2_q, a_q, b_q;
	logic signed [GW+32:0] ip_q;
	logic m_valid_q;
	logic [31:0] m_data_q;
	logic m_sat_q;

	// Stream pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [AW-1:0] k_s1, r_s2, r_s3, r_s4, r_s5;
	logic signed [GW-1:0] win1 [5];
	logic signed [GW-1:0] win2 [5];
	logic ap_s2, ap_s3, ap_s4, ap_s5;
	logic signed [31:0] prof_s2, prof_s3, prof_s4, prof_s5;
	logic signed [PW1-1:0] mc_s3, moc_s3;
	logic signed [PW2-1:0] mn_s3, mf_s3, mon_s3;
	logic signed [ACC-1:0] pa_s4, pb_s4;
	logic signed [GW-1:0] val_s5;
	logic flg_s5;

	// RAM ports
	logic [GW-1:0] g_rdata [3];
	logic g_we [3];
	logic [AW-1:0] g_waddr [3], g_raddr [3];
	logic [GW-1:0] g_wdata [3];
	logic p_we;
	logic [PAW-1:0] p_waddr, p_raddr;
	logic [31:0] p_wdata, p_rdata;

	// Combinational controls
	logic in_acc, tick_acc, strike_acc, out_load;
	logic b_we;
	logic [AW-1:0] b_waddr, prev_raddr, new_raddr;
	logic signed [GW-1:0] b_wdata;
	logic s_we;
	logic [AW-1:0] s_waddr;
	logic signed [GW-1:0] s_wdata;
	logic s_sat;
	logic [AW-1:0] a_edge, a_in1, a_out1, a_out2;
	end_mode_t cur_mode;
	logic signed [GW-1:0] d_prev, d_old, d_new;
	logic [GW:0] v1_r, v2_r, st_r, fin_r;
	logic signed [64:0] as_sum, ac_sum, as_q, ac_q;
	logic [31:0] pos;
	logic [31+NW:0] pp;
	logic signed [PW1-1:0] mc_d, moc_d;
	logic signed [PW2-1:0] mn_d, mf_d, mon_d;
	logic signed [GW:0] nsum, fsum, osum, diff;
	logic signed [GW+33:0] tsum;
	logic signed [ACC-1:0] tot;
	logic pipe_busy;

	assign prev_idx = (nw_q == 2'd2) ? 2'd0 : nw_q + 2'd1;
	assign old_idx  = (nw_q == 2'd0) ? 2'd2 : nw_q - 2'd1;
	assign d_prev = g_rdata[prev_idx];
	assign d_old  = g_rdata[old_idx];
	assign d_new  = g_rdata[nw_q];

	assign s_axis_tready = (state_q == ST_IDLE) && !clear_q;
	assign in_acc     = s_axis_tvalid && s_axis_tready;
	assign tick_acc   = in_acc && (s_axis_tuser == CMD_TICK);
	assign strike_acc = in_acc && (s_axis_tuser == CMD_STRIKE);
	assign out_load   = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);
	assign pipe_busy  = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_sat_q;

	always_comb begin
		if (gp_q == 8'd0) begin
			n_d = NW'(1);
		end else if (32'(gp_q) > MAX_POINTS) begin
			n_d = NW'(MAX_POINTS);
		end else begin
			n_d = NW'(gp_q);
		end
	end

	assign n_a = AW'(n_q);
	assign kr  = k_q - AW'(4);
	assign cur_mode = side_q ? rmode_q : lmode_q;
	assign a_edge = side_q ? n_a + AW'(2) : AW'(2);
	assign a_in1  = side_q ? n_a + AW'(1) : AW'(3);
	assign a_out1 = side_q ? n_a + AW'(3) : AW'(1);
	assign a_out2 = side_q ? n_a + AW'(4) : AW'(0);

	// Boundary values: pivoting mirrors the inner point, free extrapolates two outside points.
	always_comb begin
		if (cur_mode == END_PIVOT) begin
			v1_r = sat_grid(-ACC'(d_prev));
		end else begin
			v1_r = sat_grid(ACC'(2) * ACC'(e_q) - ACC'(d_prev));
		end
		v2_r = sat_grid(ACC'(3) * ACC'(v1_q) - ACC'(3) * ACC'(e_q) + ACC'(i_q));
	end

	// Scan rotation and readout position
	assign as_sum = 65'(rsc_q) + 65'(rcs_q) + RND30;
	assign ac_sum = 65'(rcc_q) - 65'(rss_q) + RND30;
	assign as_q = as_sum >>> 30;
	assign ac_q = ac_sum >>> 30;
	assign pos = 32'(sine_q) + 32'h4000_0000;
	assign pp  = pos * n_q;

	// Stencil products on the window
	assign nsum = (GW+1)'(win1[1]) + (GW+1)'(win1[3]);
	assign fsum = (GW+1)'(win1[0]) + (GW+1)'(win1[4]);
	assign osum = (GW+1)'(win2[1]) + (GW+1)'(win2[3]);
	assign mc_d  = coef_c_q * win1[2];
	assign moc_d = coef_oc_q * win2[2];
	assign mn_d  = coef_n_q * nsum;
	assign mf_d  = coef_f_q * fsum;
	assign mon_d = coef_on_q * osum;
	assign tot   = (pa_s4 + pb_s4 + RND28) >>> 28;
	assign st_r  = sat_grid(tot);
	assign fin_r = sat_grid(ACC'(val_s5) + ACC'(prof_s5));

	assign s_we    = v_s5;
	assign s_waddr = r_s5 + AW'(2);
	assign s_wdata = ap_s5 ? fin_r[GW-1:0] : val_s5;
	assign s_sat   = ap_s5 && fin_r[GW];

	assign diff = (GW+1)'(b_q) - (GW+1)'(a_q);
	assign tsum = (GW+34)'(ip_q) + RND31;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (tick_acc) state_d = ST_ROT_MUL;
			ST_ROT_MUL: state_d = ST_ROT_SUM;
			ST_ROT_SUM: state_d = ST_POS;
			ST_POS:     state_d = ST_B_RD_E;
			ST_B_RD_E:  state_d = ST_B_RD_I;
			ST_B_RD_I:  state_d = ST_B_CAP;
			ST_B_CAP:   state_d = ST_B_WR1;
			ST_B_WR1:   state_d = ST_B_WR2;
			ST_B_WR2:   state_d = side_q ? ST_STREAM : ST_B_RD_E;
			ST_STREAM:  if (k_q == n_a + AW'(4)) state_d = ST_DRAIN;
			ST_DRAIN:   if (!pipe_busy) state_d = ST_RD_A;
			ST_RD_A:    state_d = ST_RD_B;
			ST_RD_B:    state_d = ST_CAP_B;
			ST_CAP_B:   state_d = ST_MUL;
			ST_MUL:     state_d = ST_FIN;
			ST_FIN:     if (out_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// State-driven RAM controls
	always_comb begin
		b_we       = 1'b0;
		b_waddr    = a_edge;
		b_wdata    = '0;
		prev_raddr = k_q;
		new_raddr  = AW'(idx_q) + AW'(2);
		case (state_q)
			ST_B_RD_E: prev_raddr = a_edge;
			ST_B_RD_I: prev_raddr = a_in1;
			ST_B_WR1: begin
				b_we = (cur_mode != END_NONE);
				if (cur_mode == END_FREE) begin
					b_waddr = a_out1;
					b_wdata = v1_q;
				end
			end
			ST_B_WR2: begin
				b_we = (cur_mode != END_NONE);
				case (cur_mode)
					END_CLAMPED: b_waddr = a_in1;
					END_PIVOT: begin
						b_waddr = a_out1;
						b_wdata = v1_q;
					end
					END_FREE: begin
						b_waddr = a_out2;
						b_wdata = v2_q;
					end
					default: b_we = 1'b0;
				endcase
			end
			ST_RD_B: new_raddr = AW'(idx_q) + AW'(3);
			default: b_we = 1'b0;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (clear_q) begin
				g_we[i]    = 1'b1;
				g_waddr[i] = clr_cnt_q;
				g_wdata[i] = '0;
			end else if (2'(i) == prev_idx) begin
				g_we[i]    = b_we;
				g_waddr[i] = b_waddr;
				g_wdata[i] = b_wdata;
			end else begin
				g_we[i]    = s_we && (2'(i) == nw_q);
				g_waddr[i] = s_waddr;
				g_wdata[i] = s_wdata;
			end
			if (2'(i) == prev_idx) begin
				g_raddr[i] = prev_raddr;
			end else if (2'(i) == old_idx) begin
				g_raddr[i] = k_q;
			end else begin
				g_raddr[i] = new_raddr;
			end
		end
	end

	assign p_we    = (clear_q && (32'(clr_cnt_q) < MAX_POINTS)) ||
	                 (strike_acc && (32'(s_axis_tdata[6:0]) < MAX_POINTS));
	assign p_waddr = clear_q ? PAW'(clr_cnt_q) : PAW'(s_axis_tdata[6:0]);
	assign p_wdata = clear_q ? 32'd0 : s_axis_tdata[38:7];
	assign p_raddr = kr[PAW-1:0];

	for (genvar g = 0; g < 3; g++) begin : g_grid
		sbfd_ram #(.WIDTH(GW), .DEPTH(DEPTH)) u_grid (
			.clk   (clk),
			.we    (g_we[g]),
			.waddr (g_waddr[g]),
			.wdata (g_wdata[g]),
			.raddr (g_raddr[g]),
			.rdata (g_rdata[g])
		);
	end

	sbfd_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_strike (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_c_q  <= '0;
			coef_n_q  <= '0;
			coef_f_q  <= '0;
			coef_oc_q <= '0;
			coef_on_q <= '0;
			gp_q      <= GRID_POINTS_RST;
			lmode_q   <= END_CLAMPED;
			rmode_q   <= END_CLAMPED;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COEF_CENTER:     coef_c_q  <= cfg_wdata;
				CFG_COEF_NEAR:       coef_n_q  <= cfg_wdata;
				CFG_COEF_FAR:        coef_f_q  <= cfg_wdata;
				CFG_COEF_OLD_CENTER: coef_oc_q <= cfg_wdata;
				CFG_COEF_OLD_NEAR:   coef_on_q <= cfg_wdata;
				CFG_GRID_POINTS:     gp_q      <= cfg_wdata[7:0];
				CFG_LEFT_END_MODE:   lmode_q   <= end_mode_t'(cfg_wdata[1:0]);
				CFG_RIGHT_END_MODE:  rmode_q   <= end_mode_t'(cfg_wdata[1:0]);
				default:             gp_q      <= gp_q;
			endcase
		end
	end

	// Sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			clear_q   <= 1'b1;
			clr_cnt_q <= '0;
			sine_q    <= '0;
			cos_q     <= 32'sh4000_0000;
			struck_q  <= 1'b0;
			flag_q    <= 1'b0;
			nw_q      <= 2'd0;
			side_q    <= 1'b0;
			k_q       <= '0;
			m_valid_q <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clear_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == AW'(DEPTH - 1)) begin
					clear_q <= 1'b0;
				end
			end
			if (tick_acc) begin
				flag_q <= 1'b0;
			end
			if (state_q == ST_ROT_SUM) begin
				if (as_q > UNIT_P) begin
					sine_q <= 32'sh4000_0000;
				end else if (as_q < UNIT_N) begin
					sine_q <= -32'sh4000_0000;
				end else begin
					sine_q <= as_q[31:0];
				end
				if (ac_q > UNIT_P) begin
					cos_q <= 32'sh4000_0000;
				end else if (ac_q < UNIT_N) begin
					cos_q <= -32'sh4000_0000;
				end else begin
					cos_q <= ac_q[31:0];
				end
				if (as_q > UNIT_P || as_q < UNIT_N || ac_q > UNIT_P || ac_q < UNIT_N) begin
					flag_q <= 1'b1;
				end
			end
			if (state_q == ST_POS) begin
				side_q <= 1'b0;
			end
			if (state_q == ST_B_CAP && (cur_mode == END_PIVOT || cur_mode == END_FREE) &&
			    v1_r[GW]) begin
				flag_q <= 1'b1;
			end
			if (state_q == ST_B_WR1 && cur_mode == END_FREE && v2_r[GW]) begin
				flag_q <= 1'b1;
			end
			if (state_q == ST_B_WR2) begin
				side_q <= 1'b1;
				k_q    <= '0;
			end
			if (state_q == ST_STREAM) begin
				k_q <= k_q + AW'(1);
			end
			if ((v_s5 && (flg_s5 || s_sat)) || (v_s4 && st_r[GW])) begin
				flag_q <= 1'b1;
			end
			v_s1 <= (state_q == ST_STREAM);
			v_s2 <= v_s1 && (k_s1 >= AW'(4));
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (out_load) begin
				m_valid_q <= 1'b1;
				struck_q  <= 1'b1;
				nw_q      <= old_idx;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			sc_q <= s_axis_tdata[70:39];
			ss_q <= s_axis_tdata[102:71];
			n_q  <= n_d;
		end
		if (state_q == ST_ROT_MUL) begin
			rsc_q <= sine_q * sc_q;
			rcs_q <= cos_q * ss_q;
			rcc_q <= cos_q * sc_q;
			rss_q <= sine_q * ss_q;
		end
		if (state_q == ST_POS) begin
			idx_q  <= pp[30+NW:31];
			frac_q <= pp[30:0];
		end
		if (state_q == ST_B_RD_I) begin
			e_q <= d_prev;
		end
		if (state_q == ST_B_CAP) begin
			i_q  <= d_prev;
			v1_q <= v1_r[GW-1:0];
		end
		if (state_q == ST_B_WR1) begin
			v2_q <= v2_r[GW-1:0];
		end
		if (state_q == ST_RD_B) begin
			a_q <= d_new;
		end
		if (state_q == ST_CAP_B) begin
			b_q <= d_new;
		end
		if (state_q == ST_MUL) begin
			ip_q <= diff * $signed({1'b0, frac_q});
		end
		if (out_load) begin
			m_data_q <= 32'(a_q) + 32'(tsum >>> 31);
			m_sat_q  <= flag_q;
		end

		k_s1 <= k_q;
		if (v_s1) begin
			for (int j = 0; j < 4; j++) begin
				win1[j] <= win1[j+1];
				win2[j] <= win2[j+1];
			end
			win1[4] <= d_prev;
			win2[4] <= d_old;
		end
		r_s2    <= k_s1 - AW'(4);
		prof_s2 <= p_rdata;
		ap_s2   <= !struck_q && ((k_s1 - AW'(4)) < n_a);

		mc_s3   <= mc_d;
		moc_s3  <= moc_d;
		mn_s3   <= mn_d;
		mf_s3   <= mf_d;
		mon_s3  <= mon_d;
		r_s3    <= r_s2;
		prof_s3 <= prof_s2;
		ap_s3   <= ap_s2;

		pa_s4   <= ACC'(mc_s3) + ACC'(mn_s3) + ACC'(mf_s3);
		pb_s4   <= ACC'(moc_s3) + ACC'(mon_s3);
		r_s4    <= r_s3;
		prof_s4 <= prof_s3;
		ap_s4   <= ap_s3;

		val_s5  <= st_r[GW-1:0];
		flg_s5  <= st_r[GW];
		r_s5    <= r_s4;
		prof_s5 <= prof_s4;
		ap_s5   <= ap_s4;
	end

	`SBFD_ASSERT(a_result_from_fin, $rose(m_axis_tvalid) |-> $past(state_q) == ST_FIN, "result without finished tick")
	`SBFD_NEVER(a_no_stream_in_clear, clear_q && v_s5, "grid write during clearing pass")
	`SBFD_ASSERT(a_idle_pipe_empty, s_axis_tready |-> !(v_s1 || v_s5), "stream busy while idle")
	`SBFD_ASSERT(a_s2_follows_s1, v_s2 |-> $past(v_s1), "window stage without read data")

endmodule

[test/tb_top.sv]
// Self-checking testbench for the stiff bar finite-difference synthesizer top level.
module tb_top;
	import sbfd_pkg::*;

	localparam int PTS       = 128;
	localparam int GLEN      = PTS + 5;
	localparam int SETTLE    = 200;
	localparam int LIMIT     = 3000000;
	localparam int UNIT      = 32'sh4000_0000;
	localparam int PHASES    = 14;
	localparam int PER_PHASE = 60;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [31:0]  m_axis_tdata;
	logic         m_axis_tuser;

	stiff_bar_finite_difference_synth_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	typedef struct packed {
		logic [31:0] value;
		logic        sat;
	} sample_t;

	typedef struct {
		logic       cmd;
		logic [6:0] idx;
		int         amount;
		int         step_cos;
		int         step_sin;
		bit         known;
		int         value;
		bit         sat;
	} row_t;

	// Model of the bar: grids, profile, scan oscillator and register copies.
	int        bar_new[GLEN];
	int        bar_prev[GLEN];
	int        bar_old[GLEN];
	int        profile[PTS];
	bit        struck;
	int        scan_sin;
	int        scan_cos;
	int        w_center, w_near, w_far, w_old_center, w_old_near;
	logic [7:0] npts;
	end_mode_t left_mode, right_mode;
	bit        tick_sat;

	sample_t   pending_samples[$];
	int        mismatches;
	bit        quiet;
	int        cycles;

	function automatic int clip_grid(logic signed [71:0] v);
		if (v > 72'sd2147483647) begin
			tick_sat = 1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -72'sd2147483648) begin
			tick_sat = 1;
			return 32'sh8000_0000;
		end
		return int'(v);
	endfunction

	function automatic int clip_unit(logic signed [71:0] v);
		if (v > 72'sd1073741824) begin
			tick_sat = 1;
			return UNIT;
		end
		if (v < -72'sd1073741824) begin
			tick_sat = 1;
			return -UNIT;
		end
		return int'(v);
	endfunction

	// Boundary rule on the previous grid; out2 only matters for a free end.
	function automatic void fix_end(end_mode_t m, int e, int in1, int out1, int out2);
		logic signed [71:0] t;
		case (m)
			END_CLAMPED: begin
				bar_prev[e] = 0;
				bar_prev[in1] = 0;
			end
			END_PIVOT: begin
				bar_prev[e] = 0;
				t = -longint'(bar_prev[in1]);
				bar_prev[out1] = clip_grid(t);
			end
			END_FREE: begin
				t = 2 * longint'(bar_prev[e]) - bar_prev[in1];
				bar_prev[out1] = clip_grid(t);
				t = 3 * longint'(bar_prev[out1]) - 3 * longint'(bar_prev[e]) + bar_prev[in1];
				bar_prev[out2] = clip_grid(t);
			end
			default: ;
		endcase
	endfunction

	function automatic sample_t bar_tick(int sc, int ss);
		int n;
		logic signed [71:0] acc, acc_c;
		longint pos, prod, frac, a, b;
		int idx;
		int tmp[GLEN];
		sample_t res;
		tick_sat = 0;
		n = npts;
		if (n < 1) n = 1;
		if (n > PTS) n = PTS;
		fix_end(left_mode, 2, 3, 1, 0);
		fix_end(right_mode, n + 2, n + 1, n + 3, n + 4);
		for (int r = 0; r <= n; r++) begin
			acc = 0;
			acc += longint'(w_center) * bar_prev[r + 2];
			acc += longint'(w_near) * bar_prev[r + 3];
			acc += longint'(w_near) * bar_prev[r + 1];
			acc += longint'(w_far) * bar_prev[r + 4];
			acc += longint'(w_far) * bar_prev[r];
			acc += longint'(w_old_center) * bar_old[r + 2];
			acc += longint'(w_old_near) * bar_old[r + 3];
			acc += longint'(w_old_near) * bar_old[r + 1];
			bar_new[r + 2] = clip_grid((acc + (72'sd1 <<< 27)) >>> 28);
		end
		if (!struck) begin
			struck = 1;
			for (int r = 0; r < n; r++)
				bar_new[r + 2] = clip_grid(72'(longint'(bar_new[r + 2]) + profile[r]));
		end
		acc = 0;
		acc += longint'(scan_sin) * sc;
		acc += longint'(scan_cos) * ss;
		acc_c = 0;
		acc_c += longint'(scan_cos) * sc;
		acc_c -= longint'(scan_sin) * ss;
		scan_sin = clip_unit((acc + (72'sd1 <<< 29)) >>> 30);
		scan_cos = clip_unit((acc_c + (72'sd1 <<< 29)) >>> 30);
		pos = longint'(scan_sin) + UNIT;
		prod = pos * n;
		idx = int'(prod >>> 31) + 2;
		frac = prod & ((64'sd1 <<< 31) - 1);
		a = bar_new[idx];
		b = bar_new[idx + 1];
		acc = 72'(b - a) * 72'(frac) + (72'sd1 <<< 30);
		acc = 72'(a) + (acc >>> 31);
		res.value = acc[31:0];
		res.sat = tick_sat;
		tmp = bar_old;
		bar_old = bar_prev;
		bar_prev = bar_new;
		bar_new = tmp;
		return res;
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 26);

	// Output checker: every result transaction is matched against the oldest prediction.
	always @(posedge clk) begin
		sample_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %h sat %b", m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_samples.pop_front();
				if (m_axis_tdata !== want.value || m_axis_tuser !== want.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected value %h sat %b, got value %h sat %b",
							want.value, want.sat, m_axis_tdata, m_axis_tuser);
				end
			end
		end
	end

	task automatic set_reg(logic [2:0] index, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(posedge clk);
		case (index)
			CFG_COEF_CENTER:     w_center = data;
			CFG_COEF_NEAR:       w_near = data;
			CFG_COEF_FAR:        w_far = data;
			CFG_COEF_OLD_CENTER: w_old_center = data;
			CFG_COEF_OLD_NEAR:   w_old_near = data;
			CFG_GRID_POINTS:     npts = data[7:0];
			CFG_LEFT_END_MODE:   left_mode = end_mode_t'(data[1:0]);
			default:             right_mode = end_mode_t'(data[1:0]);
		endcase
	endtask

	// Sends one transaction; tvalid stays high afterwards unless the next call idles first.
	task automatic send(row_t r);
		sample_t res;
		if (!quiet && $urandom_range(0, 99) < 26) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.cmd;
		s_axis_tdata <= {1'b0, r.step_sin, r.step_cos, r.amount, r.idx};
		do @(posedge clk); while (!s_axis_tready);
		if (r.cmd == CMD_STRIKE) begin
			profile[r.idx] = r.amount;
		end else begin
			res = bar_tick(r.step_cos, r.step_sin);
			if (r.known) begin
				res.value = r.value;
				res.sat = r.sat;
			end
			pending_samples.push_back(res);
		end
	endtask

	task automatic drain();
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic int rand_word();
		return int'($urandom());
	endfunction

	function automatic int rand_step();
		return int'($urandom_range(0, 32'h8000_0000)) - UNIT;
	endfunction

	function automatic int rand_coef(int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	row_t directed[$] = '{
		'{CMD_STRIKE, 7'd32,  32'sh0123_4567, 0, 0, 0, 0, 0},
		'{CMD_STRIKE, 7'd127, 32'sh8000_0000, 0, 0, 0, 0, 0},
		'{CMD_STRIKE, 7'd0,   32'sh7FFF_FFFF, 0, 0, 0, 0, 0},
		'{CMD_STRIKE, 7'd63,  -1,             0, 0, 0, 0, 0},
		'{CMD_TICK,   7'd0,   0, UNIT, 0,     1, 32'sh0123_4567, 0},
		'{CMD_TICK,   7'd0,   0, UNIT, UNIT,  1, 0, 0},
		'{CMD_TICK,   7'd0,   0, UNIT, UNIT,  1, 0, 1},
		'{CMD_TICK,   7'd127, -1, -UNIT, -UNIT, 0, 0, 0},
		'{CMD_STRIKE, 7'd5,   32'sh8000_0000, 0, 0, 0, 0, 0},
		'{CMD_TICK,   7'd0,   0, -UNIT, UNIT, 0, 0, 0},
		'{CMD_TICK,   7'd0,   0, 0, 0,        0, 0, 0},
		'{CMD_TICK,   7'd0,   0, UNIT, -UNIT, 0, 0, 0},
		'{CMD_TICK,   7'd85,  32'sh5555_5555, 32'sh2AAA_AAAA, -32'sh1555_5555, 0, 0, 0},
		'{CMD_STRIKE, 7'd42,  32'sh2AAA_AAAA, 0, 0, 0, 0, 0},
		'{CMD_TICK,   7'd0,   0, UNIT, 0,     0, 0, 0}
	};

	initial begin
		row_t r;
		int gp;
		logic [31:0] c[5];
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_COEF_CENTER;
		cfg_wdata = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = CMD_TICK;
		m_axis_tready = 0;
		quiet = 0;
		cycles = 0;
		mismatches = 0;
		w_center = 0; w_near = 0; w_far = 0; w_old_center = 0; w_old_near = 0;
		npts = GRID_POINTS_RST;
		left_mode = END_CLAMPED;
		right_mode = END_CLAMPED;
		for (int i = 0; i < GLEN; i++) begin
			bar_new[i] = 0; bar_prev[i] = 0; bar_old[i] = 0;
		end
		for (int i = 0; i < PTS; i++)
			profile[i] = 0;
		struck = 0;
		scan_sin = 0;
		scan_cos = UNIT;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send(directed[i]);

		for (int p = 0; p < PHASES; p++) begin
			s_axis_tvalid <= 1'b0;
			drain();
			quiet = (p == 6);
			case (p % 7)
				0: gp = 0;
				1: gp = 255;
				2: gp = 128;
				3: gp = 1;
				4: gp = 2;
				default: gp = $urandom_range(3, 20);
			endcase
			if (p % 4 == 1) begin
				// Full-scale weights push the updates towards saturation.
				for (int k = 0; k < 5; k++)
					c[k] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			end else if (p % 4 == 3) begin
				for (int k = 0; k < 5; k++)
					c[k] = $urandom();
			end else begin
				// Roughly a stable scheme so the bar keeps ringing.
				c[0] = 32'sh1000_0000 + rand_coef(32'sh0800_0000);
				c[1] = rand_coef(32'sh0400_0000);
				c[2] = rand_coef(32'sh0100_0000);
				c[3] = -32'sh1000_0000 + rand_coef(32'sh0080_0000);
				c[4] = rand_coef(32'sh0040_0000);
			end
			set_reg(CFG_COEF_CENTER, c[0]);
			set_reg(CFG_COEF_NEAR, c[1]);
			set_reg(CFG_COEF_FAR, c[2]);
			set_reg(CFG_COEF_OLD_CENTER, c[3]);
			set_reg(CFG_COEF_OLD_NEAR, c[4]);
			set_reg(CFG_GRID_POINTS, gp);
			set_reg(CFG_LEFT_END_MODE, p % 4);
			set_reg(CFG_RIGHT_END_MODE, (p + 1 + p / 4) % 4);
			cfg_we <= 1'b0;
			@(posedge clk);
			for (int i = 0; i < PER_PHASE; i++) begin
				r.known = 0;
				r.value = 0;
				r.sat = 0;
				r.cmd = ($urandom_range(0, 99) < 15) ? CMD_STRIKE : CMD_TICK;
				r.idx = 7'($urandom());
				r.amount = rand_word();
				if ($urandom_range(0, 99) < 10) begin
					// Either raw random steps, which may leave the unit range, or a full-scale cosine of +/-1.
					if ($urandom_range(0, 1)) begin
						r.step_cos = rand_word();
						r.step_sin = rand_word();
					end else begin
						r.step_cos = $urandom_range(0, 1) ? UNIT : -UNIT;
						r.step_sin = rand_step();
					end
				end else begin
					r.step_cos = rand_step();
					r.step_sin = rand_step();
				end
				send(r);
			end
		end
		s_axis_tvalid <= 1'b0;
		drain();
		if (mismatches == 0 && pending_samples.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/sbfd_pkg.sv
rtl/sbfd_ram.sv
rtl/stiff_bar_finite_difference_synth_top.sv
test/tb_top.sv
